@@ hdl/mcp_pkg.sv @@
`default_nettype none
package mcp_pkg;

  // Code widths; each may be lowered to its minimum without touching the layout
  localparam int POSITION_CODE_BITS = 16;  // 8 .. 16
  localparam int OTHER_CODE_BITS    = 12;  // 8 .. 12

  // Fixed payload slot widths
  localparam int POS_SLOT_W   = 16;
  localparam int OTHER_SLOT_W = 12;

  localparam int LANE_COUNT = 5;
  localparam int LANE_POS   = 0;
  localparam int LANE_VEL   = 1;
  localparam int LANE_STIFF = 2;
  localparam int LANE_DAMP  = 3;
  localparam int LANE_TRQ   = 4;

  // Datapath widths
  localparam int VALUE_W     = 32;
  localparam int OFFSET_W    = 26;  // largest span is 32768000
  localparam int LEVEL_W     = POS_SLOT_W;
  localparam int PROD_W      = OFFSET_W + LEVEL_W;
  localparam int SHIFT_W     = 5;
  localparam int DIV_W       = 7;   // odd part of a span, at most 125
  localparam int NUM_W       = 24;  // shifted product is at most odd * levels
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 22;
  localparam int CODE_W      = POS_SLOT_W;

  localparam logic [LEVEL_W-1:0] POS_LEVELS   = LEVEL_W'((1 << POSITION_CODE_BITS) - 1);
  localparam logic [LEVEL_W-1:0] OTHER_LEVELS = LEVEL_W'((1 << OTHER_CODE_BITS) - 1);

  // Each span is 2^shift * divisor; recip = floor(2^RECIP_SHIFT / divisor)
  typedef struct packed {
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    logic [SHIFT_W-1:0]        shift;
    logic [DIV_W-1:0]          divisor;
    logic [RECIP_W-1:0]        recip;
    logic [LEVEL_W-1:0]        levels;
  } lane_const_t;

  localparam lane_const_t LANE_CONST [LANE_COUNT] = '{
    '{lo: -32'sd819200, hi: 32'sd819200, shift: 5'd16, divisor: 7'd25,
      recip: 22'd671088, levels: POS_LEVELS},
    '{lo: -32'sd655360, hi: 32'sd655360, shift: 5'd18, divisor: 7'd5,
      recip: 22'd3355443, levels: OTHER_LEVELS},
    '{lo: 32'sd0, hi: 32'sd32768000, shift: 5'd18, divisor: 7'd125,
      recip: 22'd134217, levels: OTHER_LEVELS},
    '{lo: 32'sd0, hi: 32'sd327680, shift: 5'd16, divisor: 7'd5,
      recip: 22'd3355443, levels: OTHER_LEVELS},
    '{lo: -32'sd458752, hi: 32'sd458752, shift: 5'd17, divisor: 7'd7,
      recip: 22'd2396745, levels: OTHER_LEVELS}
  };

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } lane_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/mcp_cmd_if.sv @@
`default_nettype none
interface mcp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_target;
  logic signed [31:0] velocity_target;
  logic signed [31:0] stiffness_gain;
  logic signed [31:0] damping_gain;
  logic signed [31:0] torque_feedforward;
  logic [7:0]         motor_address;
  logic               bus_select;

  modport source (
    output valid, position_target, velocity_target, stiffness_gain, damping_gain,
           torque_feedforward, motor_address, bus_select,
    input  ready
  );
  modport sink (
    input  valid, position_target, velocity_target, stiffness_gain, damping_gain,
           torque_feedforward, motor_address, bus_select,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/mcp_frame_if.sv @@
`default_nettype none
interface mcp_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_address;
  logic        frame_bus;
  logic [31:0] payload_upper;
  logic [31:0] payload_lower;

  modport source (
    output valid, frame_address, frame_bus, payload_upper, payload_lower,
    input  ready
  );
  modport sink (
    input  valid, frame_address, frame_bus, payload_upper, payload_lower,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/mcp_lane.sv @@
`default_nettype none
module mcp_lane
  import mcp_pkg::*;
(
  input  wire logic                       clk,
  input  wire lane_const_t                cfg,
  input  wire lane_ctrl_t                 ctrl,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic [CODE_W-1:0]               code
);

  logic signed [VALUE_W-1:0] clamped;
  logic signed [VALUE_W:0]   offset_full;
  logic [OFFSET_W-1:0]       offset;
  logic [PROD_W-1:0]         product_next;
  logic [PROD_W-1:0]         product;
  logic [PROD_W-1:0]         shifted;
  logic [NUM_W-1:0]          numer_next;
  logic [NUM_W+RECIP_W-1:0]  est_full;
  logic [CODE_W-1:0]         est_next;
  logic [NUM_W-1:0]          numer;
  logic [CODE_W-1:0]         est;
  logic [CODE_W+DIV_W-1:0]   back;
  logic [NUM_W-1:0]          remainder;

  // Stage 1: saturate, offset from the low limit, scale by the level count
  always_comb begin
    if (value < cfg.lo) begin
      clamped = cfg.lo;
    end else if (value > cfg.hi) begin
      clamped = cfg.hi;
    end else begin
      clamped = value;
    end
    offset_full  = {clamped[VALUE_W-1], clamped} - {cfg.lo[VALUE_W-1], cfg.lo};
    offset       = offset_full[OFFSET_W-1:0];
    product_next = PROD_W'(offset) * PROD_W'(cfg.levels);
  end

  // Stage 2: drop the power-of-two part of the span, estimate by reciprocal
  always_comb begin
    shifted    = product >> cfg.shift;
    numer_next = shifted[NUM_W-1:0];
    est_full   = (NUM_W+RECIP_W)'(numer_next) * (NUM_W+RECIP_W)'(cfg.recip);
    est_next   = est_full[RECIP_SHIFT +: CODE_W];
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      product <= product_next;
    end
    if (ctrl.s2_load) begin
      numer <= numer_next;
      est   <= est_next;
    end
  end

  // Estimate is at most one short of the true quotient
  always_comb begin
    back      = (CODE_W+DIV_W)'(est) * (CODE_W+DIV_W)'(cfg.divisor);
    remainder = numer - NUM_W'(back);
    if (remainder >= NUM_W'(cfg.divisor)) begin
      code = est + CODE_W'(1);
    end else begin
      code = est;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mcp_merge.sv @@
`default_nettype none
module mcp_merge
  import mcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  input  wire logic [CODE_W-1:0] codes [LANE_COUNT],
  input  wire logic [7:0]        address,
  input  wire logic              bus,
  output logic                   ready,
  mcp_frame_if.source            frame
);

  logic [63:0] word;

  always_comb begin
    word = {codes[LANE_POS][POS_SLOT_W-1:0],
            codes[LANE_VEL][OTHER_SLOT_W-1:0],
            codes[LANE_STIFF][OTHER_SLOT_W-1:0],
            codes[LANE_DAMP][OTHER_SLOT_W-1:0],
            codes[LANE_TRQ][OTHER_SLOT_W-1:0]};
    ready = !frame.valid || frame.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (ready) begin
      frame.valid <= load_valid;
    end
    if (ready && load_valid) begin
      frame.frame_address <= address;
      frame.frame_bus     <= bus;
      frame.payload_upper <= word[63:32];
      frame.payload_lower <= word[31:0];
    end
  end

endmodule
`default_nettype wire

@@ hdl/mit_motor_command_packer_unit.sv @@
// A beat passes the stage 1, stage 2 and frame registers in turn; a stall can hold it.
// One command beat per cycle while the frame sink keeps up; five quantizer lanes run side
// by side and the merge register packs their codes, so no stage is ever reused.
// Each stage collapses bubbles, so input is taken while a frame waits downstream.
// Reset (rst, synchronous) empties all stages; no payload register is cleared.
`default_nettype none
module mit_motor_command_packer_unit
  import mcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mcp_cmd_if.sink     cmd,
  mcp_frame_if.source frame
);

  logic                      s1_valid;
  logic                      s2_valid;
  logic                      s1_free;
  logic                      s2_free;
  logic                      merge_ready;
  lane_ctrl_t                lane_ctrl;
  logic signed [VALUE_W-1:0] lane_value [LANE_COUNT];
  logic [CODE_W-1:0]         lane_code  [LANE_COUNT];
  logic [7:0]                s1_address;
  logic [7:0]                s2_address;
  logic                      s1_bus;
  logic                      s2_bus;

  // A stage advances when it is empty or the stage after it takes its beat
  always_comb begin
    s2_free           = !s2_valid || merge_ready;
    s1_free           = !s1_valid || s2_free;
    cmd.ready         = s1_free;
    lane_ctrl.s1_load = s1_free;
    lane_ctrl.s2_load = s2_free;
  end

  always_comb begin
    lane_value[LANE_POS]   = cmd.position_target;
    lane_value[LANE_VEL]   = cmd.velocity_target;
    lane_value[LANE_STIFF] = cmd.stiffness_gain;
    lane_value[LANE_DAMP]  = cmd.damping_gain;
    lane_value[LANE_TRQ]   = cmd.torque_feedforward;
  end

  // Stage valids and the id/bus sideband that travels beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= cmd.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
    if (s1_free) begin
      s1_address <= cmd.motor_address;
      s1_bus     <= cmd.bus_select;
    end
    if (s2_free) begin
      s2_address <= s1_address;
      s2_bus     <= s1_bus;
    end
  end

  // One quantizer lane per command value; constants select the range
  for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
    mcp_lane u_lane (
      .clk   (clk),
      .cfg   (LANE_CONST[i]),
      .ctrl  (lane_ctrl),
      .value (lane_value[i]),
      .code  (lane_code[i])
    );
  end

  // Pack the corrected lane codes into the payload and hold it for the sink
  mcp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s2_valid),
    .codes      (lane_code),
    .address    (s2_address),
    .bus        (s2_bus),
    .ready      (merge_ready),
    .frame      (frame)
  );

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !s1_valid && !s2_valid && !frame.valid)
    else $error("pipeline not empty after reset");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> s1_valid)
    else $error("accepted beat lost at stage 1");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid)
    else $error("stalled stage 1 beat dropped");

  a_s2_to_frame: assert property (@(posedge clk) disable iff (rst)
    s2_valid && merge_ready |=> frame.valid)
    else $error("stage 2 beat not delivered to frame register");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import mcp_pkg::*;

  // Clamp limits of each command value, as Q15.16 integers
  localparam int POS_MIN   = -819200;    // -12.5 rad
  localparam int POS_MAX   = 819200;     //  12.5 rad
  localparam int VEL_MIN   = -655360;    // -10 rad/s
  localparam int VEL_MAX   = 655360;     //  10 rad/s
  localparam int STIFF_MIN = 0;
  localparam int STIFF_MAX = 32768000;   // 500
  localparam int DAMP_MIN  = 0;
  localparam int DAMP_MAX  = 327680;     // 5
  localparam int TRQ_MIN   = -458752;    // -7 N*m
  localparam int TRQ_MAX   = 458752;     //  7 N*m

  localparam int RANDOM_BEATS = 1700;
  localparam int TAIL_BEATS   = 200;     // no idling on either side in this last stretch
  localparam int DRAIN_AT     = 900;     // sender holds here until every frame is out
  localparam int SETTLE_CYCLES = 8;      // pipeline is 3 deep; allow a few more
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] stiffness;
    logic signed [31:0] damping;
    logic signed [31:0] torque;
    logic [7:0]         address;
    logic               bus;
  } motor_cmd_t;

  typedef struct packed {
    logic [7:0]  address;
    logic        bus;
    logic [31:0] upper;
    logic [31:0] lower;
  } can_frame_t;

  logic clk;
  logic rst;

  mcp_cmd_if   cmd_link ();
  mcp_frame_if frame_link ();

  mit_motor_command_packer_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_link),
    .frame (frame_link)
  );

  motor_cmd_t command_backlog [$];   // commands not yet offered to the block
  can_frame_t frames_awaited [$];    // packed frames owed by the block, oldest first
  motor_cmd_t cmd_now;               // command currently held on the input channel
  int         planned_beats;
  int         accepted_beats;
  int         error_count;
  int         cycle_count;
  int         gap_left;
  int         stall_left;
  logic       calm_tail;

  // Free-running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp one value to [lo, hi] and scale it onto 0 .. 2^bits - 1, rounding down.
  // The Q scale appears in both offset and span, so it cancels out of the quotient.
  function automatic logic [15:0] quantize_code(logic signed [31:0] value, longint lo,
                                                longint hi, int bits);
    longint v;
    longint levels;
    v = longint'(value);
    levels = (longint'(1) << bits) - 1;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return 16'(((v - lo) * levels) / (hi - lo));
  endfunction

  // Build the frame the block should emit for one command: codes go big-endian
  // into a 64-bit payload, id and bus pass through untouched.
  function automatic can_frame_t pack_frame(motor_cmd_t c);
    can_frame_t f;
    logic [63:0] payload;
    logic [15:0] pos_code;
    logic [15:0] vel_code;
    logic [15:0] stiff_code;
    logic [15:0] damp_code;
    logic [15:0] trq_code;
    pos_code   = quantize_code(c.position, POS_MIN, POS_MAX, POSITION_CODE_BITS);
    vel_code   = quantize_code(c.velocity, VEL_MIN, VEL_MAX, OTHER_CODE_BITS);
    stiff_code = quantize_code(c.stiffness, STIFF_MIN, STIFF_MAX, OTHER_CODE_BITS);
    damp_code  = quantize_code(c.damping, DAMP_MIN, DAMP_MAX, OTHER_CODE_BITS);
    trq_code   = quantize_code(c.torque, TRQ_MIN, TRQ_MAX, OTHER_CODE_BITS);
    // Narrow codes sit zero-extended in the low bits of their slots
    payload = {pos_code, vel_code[11:0], stiff_code[11:0], damp_code[11:0], trq_code[11:0]};
    f.address = c.address;
    f.bus     = c.bus;
    f.upper   = payload[63:32];
    f.lower   = payload[31:0];
    return f;
  endfunction

  function automatic motor_cmd_t make_cmd(int p, int v, int k, int d, int t,
                                          logic [7:0] addr, logic bus);
    motor_cmd_t c;
    c.position  = p;
    c.velocity  = v;
    c.stiffness = k;
    c.damping   = d;
    c.torque    = t;
    c.address   = addr;
    c.bus       = bus;
    return c;
  endfunction

  // Mostly in-range values, a share hugging the clamp edges, and some raw 32-bit noise
  function automatic logic signed [31:0] pick_value(int lo, int hi);
    int mode;
    mode = $urandom_range(9);
    if (mode <= 5) return lo + int'($urandom_range(hi - lo));
    if (mode <= 7) return ($urandom_range(1) ? lo : hi) + int'($urandom_range(6)) - 3;
    return $urandom;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
    error_count++;
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, seen, wanted);
  endtask

  // Stimulus list, reset, and end of run
  initial begin
    cmd_link.valid              = 1'b0;
    cmd_link.position_target    = '0;
    cmd_link.velocity_target    = '0;
    cmd_link.stiffness_gain     = '0;
    cmd_link.damping_gain       = '0;
    cmd_link.torque_feedforward = '0;
    cmd_link.motor_address      = '0;
    cmd_link.bus_select         = 1'b0;
    frame_link.ready            = 1'b0;
    rst = 1'b1;

    // Directed: zero, exact limits, one step inside and outside each limit,
    // full-scale saturation both ways, midpoints, and alternating bit patterns
    command_backlog.push_back(make_cmd(0, 0, 0, 0, 0, 8'h00, 1'b0));
    command_backlog.push_back(make_cmd(POS_MIN, VEL_MIN, STIFF_MIN, DAMP_MIN, TRQ_MIN,
                                       8'h01, 1'b0));
    command_backlog.push_back(make_cmd(POS_MAX, VEL_MAX, STIFF_MAX, DAMP_MAX, TRQ_MAX,
                                       8'hFE, 1'b1));
    command_backlog.push_back(make_cmd(POS_MIN - 1, VEL_MIN - 1, STIFF_MIN - 1, DAMP_MIN - 1,
                                       TRQ_MIN - 1, 8'h10, 1'b1));
    command_backlog.push_back(make_cmd(POS_MAX + 1, VEL_MAX + 1, STIFF_MAX + 1, DAMP_MAX + 1,
                                       TRQ_MAX + 1, 8'h20, 1'b0));
    command_backlog.push_back(make_cmd(POS_MIN + 1, VEL_MIN + 1, STIFF_MIN + 1, DAMP_MIN + 1,
                                       TRQ_MIN + 1, 8'h30, 1'b1));
    command_backlog.push_back(make_cmd(POS_MAX - 1, VEL_MAX - 1, STIFF_MAX - 1, DAMP_MAX - 1,
                                       TRQ_MAX - 1, 8'h40, 1'b0));
    command_backlog.push_back(make_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000, 8'hFF, 1'b1));
    command_backlog.push_back(make_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 1'b0));
    command_backlog.push_back(make_cmd(-1, -1, -1, -1, -1, 8'hFF, 1'b0));
    command_backlog.push_back(make_cmd(0, 0, STIFF_MAX / 2, DAMP_MAX / 2, 0, 8'h7F, 1'b1));
    command_backlog.push_back(make_cmd(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                       32'hAAAA_AAAA, 32'hAAAA_AAAA, 8'hAA, 1'b1));
    command_backlog.push_back(make_cmd(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                       32'h5555_5555, 32'h5555_5555, 8'h55, 1'b0));
    command_backlog.push_back(make_cmd(32'h0000_5555, 32'hFFFF_AAAA, 32'h0155_5555,
                                       32'h0002_AAAA, 32'hFFFA_AAAA, 8'h80, 1'b1));
    command_backlog.push_back(make_cmd(POS_MIN, VEL_MAX, STIFF_MIN, DAMP_MAX, TRQ_MIN,
                                       8'h0F, 1'b0));
    command_backlog.push_back(make_cmd(POS_MAX, VEL_MIN, STIFF_MAX, DAMP_MIN, TRQ_MAX,
                                       8'hF0, 1'b1));

    repeat (RANDOM_BEATS) begin
      command_backlog.push_back(make_cmd(pick_value(POS_MIN, POS_MAX),
                                         pick_value(VEL_MIN, VEL_MAX),
                                         pick_value(STIFF_MIN, STIFF_MAX),
                                         pick_value(DAMP_MIN, DAMP_MAX),
                                         pick_value(TRQ_MIN, TRQ_MAX),
                                         8'($urandom_range(255)), 1'($urandom_range(1))));
    end
    planned_beats = command_backlog.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to go in and every frame to come out, then let it settle
    while (accepted_beats != planned_beats || frames_awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  assign calm_tail = (accepted_beats >= planned_beats - TAIL_BEATS);

  // Command driver: hold a beat until it is taken, insert random idle bursts between
  // beats, and once midway hold off until the block is drained.
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      cmd_link.valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = cmd_link.valid;
      if (cmd_link.valid && cmd_link.ready) begin
        frames_awaited.push_back(pack_frame(cmd_now));
        accepted_beats++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm_tail && $urandom_range(5) == 0) begin
          // this cycle is the first of the burst
          gap_left = $urandom_range(3);
        end else if (command_backlog.size() != 0 &&
                     !(accepted_beats == DRAIN_AT && frames_awaited.size() != 0)) begin
          cmd_now = command_backlog.pop_front();
          cmd_link.position_target    <= cmd_now.position;
          cmd_link.velocity_target    <= cmd_now.velocity;
          cmd_link.stiffness_gain     <= cmd_now.stiffness;
          cmd_link.damping_gain       <= cmd_now.damping;
          cmd_link.torque_feedforward <= cmd_now.torque;
          cmd_link.motor_address      <= cmd_now.address;
          cmd_link.bus_select         <= cmd_now.bus;
          next_valid = 1'b1;
        end
      end
      cmd_link.valid <= next_valid;
    end
  end

  // Frame monitor: check each accepted frame against the oldest owed one,
  // and stall ready in random bursts.
  always @(posedge clk) begin
    logic       next_ready;
    can_frame_t wanted;
    if (rst) begin
      frame_link.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (frame_link.valid && frame_link.ready) begin
        if (frames_awaited.size() == 0) begin
          note_mismatch("frame with none owed, payload_upper", frame_link.payload_upper, '0);
        end else begin
          wanted = frames_awaited.pop_front();
          if (frame_link.frame_address !== wanted.address)
            note_mismatch("frame_address", 32'(frame_link.frame_address), 32'(wanted.address));
          if (frame_link.frame_bus !== wanted.bus)
            note_mismatch("frame_bus", 32'(frame_link.frame_bus), 32'(wanted.bus));
          if (frame_link.payload_upper !== wanted.upper)
            note_mismatch("payload_upper", frame_link.payload_upper, wanted.upper);
          if (frame_link.payload_lower !== wanted.lower)
            note_mismatch("payload_lower", frame_link.payload_lower, wanted.lower);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!calm_tail && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(3);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      frame_link.ready <= next_ready;
    end
  end

endmodule
